// ===== rtl/timestamp_ordered_frame_queue_unit_macros.svh =====
// assertion macros for the timestamp ordered frame queue
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef TIMESTAMP_ORDERED_FRAME_QUEUE_UNIT_MACROS_SVH
`define TIMESTAMP_ORDERED_FRAME_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define TOFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TOFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tofq_pkg.sv =====
// shared types and codes for the timestamp ordered frame queue
// no dependencies
package tofq_pkg;

  localparam int StampBits = 64;
  localparam int IdBits    = 16;
  localparam int CountBits = 5;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_POP_LESS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic signed [StampBits-1:0] stamp;
    logic [IdBits-1:0]           frame_id;
  } in_item_t;

  typedef struct packed {
    logic                        popped;
    logic [IdBits-1:0]           out_frame_id;
    logic signed [StampBits-1:0] out_stamp;
    logic [CountBits-1:0]        entry_count;
    logic                        push_refused;
  } out_item_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== rtl/tofq_cell.sv =====
// one slot of the sorted shift chain: holds a stamp and a handle
// depends on tofq_pkg
module tofq_cell import tofq_pkg::*; #(
  parameter int FrameBits = 16
) (
  input  logic                        clk_i,
  input  cell_ctrl_t                  ctrl_i,
  input  logic                        valid_i,
  input  logic signed [StampBits-1:0] new_stamp_i,
  input  logic [FrameBits-1:0]        new_frame_i,
  input  logic                        left_lt_i,
  input  logic signed [StampBits-1:0] left_stamp_i,
  input  logic [FrameBits-1:0]        left_frame_i,
  input  logic signed [StampBits-1:0] right_stamp_i,
  input  logic [FrameBits-1:0]        right_frame_i,
  output logic                        lt_o,
  output logic signed [StampBits-1:0] stamp_o,
  output logic [FrameBits-1:0]        frame_o
);

  logic signed [StampBits-1:0] stamp_q, stamp_d;
  logic [FrameBits-1:0]        frame_q, frame_d;

  assign lt_o = valid_i && (stamp_q < new_stamp_i);

  always_comb begin
    stamp_d = stamp_q;
    frame_d = frame_q;
    if (ctrl_i.push) begin
      if (!lt_o) begin
        // insertion point sits where the left neighbor is still smaller
        if (left_lt_i) begin
          stamp_d = new_stamp_i;
          frame_d = new_frame_i;
        end else begin
          stamp_d = left_stamp_i;
          frame_d = left_frame_i;
        end
      end
    end else if (ctrl_i.pop) begin
      stamp_d = right_stamp_i;
      frame_d = right_frame_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    frame_q <= frame_d;
  end

  assign stamp_o = stamp_q;
  assign frame_o = frame_q;

endmodule

// ===== rtl/timestamp_ordered_frame_queue_unit.sv =====
// top level of the timestamp ordered frame queue: cell chain, count, result register
// depends on tofq_pkg, tofq_cell and the assertion macro header
`include "timestamp_ordered_frame_queue_unit_macros.svh"

// Sorted queue of up to QUEUE_DEPTH frame handles keyed by signed 64-bit
// timestamp, head holds the smallest stamp, newest first among equals. Each
// command (push, pop, pop if head earlier than limit, clear) acts on the
// whole chain: every cell compares its stamp with the incoming one in
// parallel and shifts left or right by one, so a beat can be accepted every
// cycle unless the input stalls, and its result is registered on the output.
// The input stalls only while a finished result is held by a stalled output. Slots
// need no clearing after reset; the entry count alone marks which cells are live.
module timestamp_ordered_frame_queue_unit import tofq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int FrameBits = (HANDLE_BITS < IdBits) ? HANDLE_BITS : IdBits;
  localparam int CntW      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0] occ_q, occ_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic                        in_acc;
  logic                        full;
  logic                        pop_fire;
  cell_ctrl_t                  ctrl;
  logic [FrameBits-1:0]        new_frame;
  logic [QUEUE_DEPTH-1:0]      lt;
  logic [QUEUE_DEPTH-1:0]      left_lt;
  logic signed [StampBits-1:0] stamps   [QUEUE_DEPTH];
  logic [FrameBits-1:0]        frames   [QUEUE_DEPTH];
  logic signed [StampBits-1:0] l_stamps [QUEUE_DEPTH];
  logic [FrameBits-1:0]        l_frames [QUEUE_DEPTH];
  logic signed [StampBits-1:0] r_stamps [QUEUE_DEPTH];
  logic [FrameBits-1:0]        r_frames [QUEUE_DEPTH];
  logic [CntW+CountBits-1:0]   cnt_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (occ_q >= FullCnt);
  assign new_frame  = in_item_i.frame_id[FrameBits-1:0];

  // lt[0] already includes the head being live
  assign pop_fire = in_acc &&
                    (((in_item_i.cmd == CMD_POP) && (occ_q != '0)) ||
                     ((in_item_i.cmd == CMD_POP_LESS) && lt[0]));

  assign ctrl.push = in_acc && (in_item_i.cmd == CMD_PUSH) && !full;
  assign ctrl.pop  = pop_fire;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] CellIdx = CntW'(i);

    if (i == 0) begin : g_head
      assign left_lt[i]  = 1'b1;
      assign l_stamps[i] = '0;
      assign l_frames[i] = '0;
    end else begin : g_mid
      assign left_lt[i]  = lt[i-1];
      assign l_stamps[i] = stamps[i-1];
      assign l_frames[i] = frames[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_stamps[i] = '0;
      assign r_frames[i] = '0;
    end else begin : g_body
      assign r_stamps[i] = stamps[i+1];
      assign r_frames[i] = frames[i+1];
    end

    tofq_cell #(
      .FrameBits(FrameBits)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (CellIdx < occ_q),
      .new_stamp_i  (in_item_i.stamp),
      .new_frame_i  (new_frame),
      .left_lt_i    (left_lt[i]),
      .left_stamp_i (l_stamps[i]),
      .left_frame_i (l_frames[i]),
      .right_stamp_i(r_stamps[i]),
      .right_frame_i(r_frames[i]),
      .lt_o         (lt[i]),
      .stamp_o      (stamps[i]),
      .frame_o      (frames[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (in_acc) begin
      if (in_item_i.cmd == CMD_CLEAR) begin
        occ_d = '0;
      end else if (ctrl.push) begin
        occ_d = occ_q + CntW'(1);
      end else if (pop_fire) begin
        occ_d = occ_q - CntW'(1);
      end
    end
  end

  assign cnt_ext = {{CountBits{1'b0}}, occ_d};

  always_comb begin
    out_d              = out_q;
    out_d.popped       = pop_fire;
    out_d.out_frame_id = pop_fire ? IdBits'(frames[0]) : '0;
    out_d.out_stamp    = pop_fire ? stamps[0] : '0;
    out_d.entry_count  = cnt_ext[CountBits-1:0];
    out_d.push_refused = (in_item_i.cmd == CMD_PUSH) && full;
  end

  assign out_valid_d = in_acc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload loads only with an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TOFQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= FullCnt, "occupancy above queue depth")
  `TOFQ_ASSERT_NOW(a_head_sorted, occ_q >= CntW'(2), !(stamps[1] < stamps[0]),
    "head pair out of order")
  `TOFQ_ASSERT_NEXT(a_refused, in_acc && (in_item_i.cmd == CMD_PUSH) && full,
    out_valid_q && out_q.push_refused && (occ_q == FullCnt), "full push not refused")
  `TOFQ_ASSERT_NEXT(a_pop_count, pop_fire, occ_q == $past(occ_q) - CntW'(1),
    "pop did not drop the count")

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the timestamp ordered frame queue unit
// drives random and directed command beats, predicts every result in-bench
// depends on tofq_pkg and the timestamp_ordered_frame_queue_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import tofq_pkg::*;

  localparam int QueueDepth = 16;
  localparam int HandleBits = 16;
  localparam int RandomBeats = 1500;
  localparam int LongHold = 60;
  localparam int IdleLimit = 2000;
  localparam int MaxShown = 10;
  localparam int BufBits = 12;
  localparam int BufDepth = 1 << BufBits;

  localparam logic [IdBits-1:0] HandleMask = IdBits'((64'd1 << HandleBits) - 64'd1);
  localparam logic signed [StampBits-1:0] StampMax = {1'b0, {(StampBits-1){1'b1}}};
  localparam logic signed [StampBits-1:0] StampMin = {1'b1, {(StampBits-1){1'b0}}};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  timestamp_ordered_frame_queue_unit #(
    .QUEUE_DEPTH(QueueDepth),
    .HANDLE_BITS(HandleBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // beats waiting to be offered, and results the queue model says must come back
  // both are rings indexed by free-running write and read counts
  in_item_t  pending_beats[BufDepth];
  out_item_t expected_results[BufDepth];
  int        pend_wr = 0;
  int        pend_rd = 0;
  int        exp_wr = 0;
  int        exp_rd = 0;

  // shadow copy of the sorted queue
  logic signed [StampBits-1:0] held_stamp[QueueDepth];
  logic [IdBits-1:0]           held_frame[QueueDepth];
  int                          held_count;

  logic in_fire_q;
  logic out_fire_q;
  bit   no_idle = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;

  int mismatches = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int frames_returned = 0;
  int pushes_refused = 0;
  int full_seen = 0;

  // one queue operation on the shadow copy; returns the result beat it should produce
  function automatic out_item_t apply_queue_op(in_item_t beat);
    out_item_t                   res;
    logic signed [StampBits-1:0] key;
    int                          slot;
    int                          i;
    bit                          take;
    res  = '0;
    key  = beat.stamp;
    take = 1'b0;
    case (cmd_e'(beat.cmd))
      CMD_PUSH: begin
        if (held_count >= QueueDepth) begin
          res.push_refused = 1'b1;
        end else begin
          // lands ahead of the first entry that is not earlier, so newest wins ties
          slot = 0;
          while (slot < held_count && held_stamp[slot] < key) slot++;
          for (i = held_count; i > slot; i--) begin
            held_stamp[i] = held_stamp[i-1];
            held_frame[i] = held_frame[i-1];
          end
          held_stamp[slot] = key;
          held_frame[slot] = beat.frame_id & HandleMask;
          held_count++;
        end
      end
      CMD_POP:      take = (held_count > 0);
      CMD_POP_LESS: take = (held_count > 0) && (held_stamp[0] < key);
      CMD_CLEAR:    held_count = 0;
      default: ;
    endcase
    if (take) begin
      res.popped       = 1'b1;
      res.out_frame_id = held_frame[0];
      res.out_stamp    = held_stamp[0];
      for (i = 1; i < held_count; i++) begin
        held_stamp[i-1] = held_stamp[i];
        held_frame[i-1] = held_frame[i];
      end
      held_count--;
    end
    res.entry_count = CountBits'(held_count);
    return res;
  endfunction

  task automatic log_mismatch(string msg);
    if (mismatches < MaxShown) $display("%s", msg);
    mismatches++;
  endtask

  // sender: one beat at a time from the pending ring, random gap after each
  always @(negedge clk) begin : drive_beats
    in_item_t beat;
    logic     nxt_valid;
    int       send_gap;
    if (rst_n && (!in_valid || in_fire_q)) begin
      nxt_valid = 1'b0;
      beat = in_item;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pend_wr != pend_rd) begin
        beat = pending_beats[pend_rd[BufBits-1:0]];
        pend_rd++;
        nxt_valid = 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 8);
      end
      in_valid <= nxt_valid;
      in_item  <= beat;
    end
  end

  // receiver: random stall before each result, plus long holds on request
  always @(negedge clk) begin : drive_stall
    int   recv_wait;
    int   hold_left;
    logic stall;
    if (rst_n) begin
      if (hold_served != hold_requests) begin
        hold_left = LongHold;
        hold_served++;
      end
      if (out_fire_q) recv_wait = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall <= stall;
    end
  end

  // monitor: check the result beat first, then predict the accepted command beat
  always @(posedge clk or negedge rst_n) begin : watch_beats
    out_item_t want;
    if (!rst_n) begin
      in_fire_q  <= 1'b0;
      out_fire_q <= 1'b0;
      held_count = 0;
    end else begin
      in_fire_q  <= in_valid && !in_stall;
      out_fire_q <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          log_mismatch($sformatf(
            "unexpected result: popped=%0b id=%h stamp=%0d count=%0d refused=%0b",
            out_item.popped, out_item.out_frame_id, out_item.out_stamp,
            out_item.entry_count, out_item.push_refused));
        end else begin
          want = expected_results[exp_rd[BufBits-1:0]];
          exp_rd++;
          if (out_item.popped !== want.popped || out_item.out_frame_id !== want.out_frame_id ||
              out_item.out_stamp !== want.out_stamp ||
              out_item.entry_count !== want.entry_count ||
              out_item.push_refused !== want.push_refused) begin
            log_mismatch($sformatf({"result %0d: expected popped=%0b id=%h stamp=%0d ",
                                    "count=%0d refused=%0b, got popped=%0b id=%h ",
                                    "stamp=%0d count=%0d refused=%0b"},
              results_checked, want.popped, want.out_frame_id, want.out_stamp,
              want.entry_count, want.push_refused, out_item.popped, out_item.out_frame_id,
              out_item.out_stamp, out_item.entry_count, out_item.push_refused));
          end
          if (want.popped) frames_returned++;
          if (want.push_refused) pushes_refused++;
          if (want.entry_count == CountBits'(QueueDepth)) full_seen++;
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results[exp_wr[BufBits-1:0]] = apply_queue_op(in_item);
        exp_wr++;
        beats_sent++;
      end
    end
  end

  // ends the run when neither side has moved for too long
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a beat", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic queue_beat(cmd_e c, logic signed [StampBits-1:0] s, logic [IdBits-1:0] id);
    in_item_t beat;
    beat.cmd      = c;
    beat.stamp    = s;
    beat.frame_id = id;
    pending_beats[pend_wr[BufBits-1:0]] = beat;
    pend_wr++;
  endtask

  task automatic wait_for_drain();
    while (pend_wr != pend_rd || in_valid || exp_wr != exp_rd)
      @(posedge clk);
  endtask

  // 0: tiny range around zero, 1: any pattern, 2: corner values, 3: cluster near base
  function automatic logic signed [StampBits-1:0] pick_stamp(int unsigned mode,
                                                            logic signed [StampBits-1:0] base);
    logic signed [StampBits-1:0] s;
    int                          off;
    case (mode)
      0: begin
        off = int'($urandom_range(0, 6)) - 3;
        s = StampBits'(off);
      end
      1: s = {$urandom, $urandom};
      2: begin
        case ($urandom_range(0, 6))
          0: s = StampMin;
          1: s = StampMin + 1;
          2: s = -1;
          3: s = 0;
          4: s = 1;
          5: s = StampMax - 1;
          default: s = StampMax;
        endcase
      end
      default: begin
        off = int'($urandom_range(0, 16)) - 8;
        s = base + StampBits'(off);
      end
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int                          k;
    int                          phase;
    int                          len;
    int                          sent_random;
    int unsigned                 kind;
    int unsigned                 mode;
    int unsigned                 r;
    int unsigned                 push_pct;
    int unsigned                 pop_pct;
    int unsigned                 less_pct;
    logic signed [StampBits-1:0] base;
    logic signed [StampBits-1:0] fill_stamp;
    cmd_e                        c;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pops, corner stamps, ties, strict limit, fill to the top, clear
    queue_beat(CMD_POP, 0, 16'h0000);
    queue_beat(CMD_PUSH, StampMax, 16'hFFFF);
    queue_beat(CMD_PUSH, StampMin, 16'h0000);
    queue_beat(CMD_PUSH, StampMin, 16'h1234);
    queue_beat(CMD_POP_LESS, StampMin, 16'h0000);
    queue_beat(CMD_POP_LESS, StampMin + 1, 16'h0000);
    queue_beat(CMD_POP, 0, 16'h0000);
    for (k = 0; k < QueueDepth - 1; k++) begin
      fill_stamp = StampBits'((k % 5) - 2);
      queue_beat(CMD_PUSH, fill_stamp, IdBits'($urandom));
    end
    queue_beat(CMD_PUSH, StampMin, 16'hBEEF);
    queue_beat(CMD_POP_LESS, StampMax, 16'h0000);
    queue_beat(CMD_CLEAR, {$urandom, $urandom}, 16'h0000);
    queue_beat(CMD_POP, 0, 16'h0000);
    wait_for_drain();

    phase = 0;
    sent_random = 0;
    while (sent_random < RandomBeats) begin
      kind = $urandom_range(0, 3);
      mode = $urandom_range(0, 3);
      base = {$urandom, $urandom};
      len  = $urandom_range(15, 60);
      no_idle = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin push_pct = 75; pop_pct = 10; less_pct = 13; end  // fill up
        1: begin push_pct = 20; pop_pct = 40; less_pct = 38; end  // drain
        2: begin push_pct = 45; pop_pct = 20; less_pct = 32; end
        default: begin push_pct = 25; pop_pct = 25; less_pct = 25; mode = 1; end  // noise
      endcase
      // output held off while the sender keeps offering beats
      if (phase % 6 == 1) hold_requests++;
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) c = CMD_PUSH;
        else if (r < push_pct + pop_pct) c = CMD_POP;
        else if (r < push_pct + pop_pct + less_pct) c = CMD_POP_LESS;
        else c = CMD_CLEAR;
        queue_beat(c, pick_stamp(mode, base), IdBits'($urandom));
      end
      sent_random += len;
      // sender holds back until every result is home
      if (phase % 4 == 3) wait_for_drain();
      phase++;
    end

    no_idle = 1'b0;
    wait_for_drain();
    repeat (5) @(posedge clk);

    $display("%0d beats sent over %0d random phases, %0d results checked", beats_sent, phase,
             results_checked);
    $display("%0d frames returned, %0d pushes refused, %0d results at full depth, %0d long holds",
             frames_returned, pushes_refused, full_seen, hold_served);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, exp_wr - exp_rd);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
